// File: rtl/core/page_frame_stack_allocator_core_macros.svh
// Assertion macros shared by the page frame stack allocator RTL.
`ifndef PAGE_FRAME_STACK_ALLOCATOR_CORE_MACROS_SVH
`define PAGE_FRAME_STACK_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, skipped while reset is asserted
`define PFSA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, skipped while reset is asserted
`define PFSA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/pfsa_pkg.sv
// Types, constants and codes of the page frame stack allocator.
package pfsa_pkg;

    localparam int CAPACITY   = 4096;
    localparam int PAGE_BYTES = 4096;
    localparam int ADDR_W     = 32;
    localparam int ACT_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int FREE_W     = 13;

    localparam int DEPTH_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int IN_TDATA_W  = ((3 * ADDR_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((ADDR_W + FREE_W + 7) / 8) * 8;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [DEPTH_W-1:0] depth_t;

    localparam addr_t PAGE_MASK = addr_t'(PAGE_BYTES - 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_FREE   = 2'd1,
        ACT_ENROLL = 2'd2
    } pfsa_action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_ZERO     = 2'd2,
        ST_OVERFLOW = 2'd3
    } pfsa_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GRANT,
        S_ENROLL,
        S_FINISH
    } pfsa_state_t;

    typedef struct packed {
        logic capture;
        logic take_grant;
        logic enroll_step;
        logic emit;
    } pfsa_cmd_t;

    typedef struct packed {
        pfsa_action_t action;
        logic         depth_zero;
        logic         enroll_empty;
        logic         last_page;
        logic         step_overflow;
        logic         out_free;
    } pfsa_flags_t;

endpackage

// File: rtl/core/pfsa_datapath.sv
// Datapath: free stack memory, stack depth, enroll walk and result register.
module pfsa_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [pfsa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic [pfsa_pkg::ACT_W-1:0]          s_axis_tuser,
    input  pfsa_pkg::pfsa_cmd_t                 cmd,
    output pfsa_pkg::pfsa_flags_t               flags,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [pfsa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic [pfsa_pkg::STATUS_W-1:0]       m_axis_tuser
);
    import pfsa_pkg::*;

    addr_t              stack_mem [CAPACITY];
    addr_t              rd_data_reg;

    depth_t             depth_reg, depth_next;
    addr_t              top_reg, top_next;
    addr_t              base_reg, base_next;
    pfsa_status_t       status_reg, status_next;
    addr_t              granted_reg, granted_next;

    logic               m_valid_reg, m_valid_next;
    pfsa_status_t       out_status_reg, out_status_next;
    addr_t              out_granted_reg, out_granted_next;
    logic [FREE_W-1:0]  out_pages_reg, out_pages_next;

    logic               mem_we, mem_re;
    logic [IDX_W-1:0]   mem_waddr, mem_raddr;
    addr_t              mem_wdata;

    addr_t              page_addr, range_start, range_end;
    logic [ADDR_W:0]    start_sum;
    addr_t              start_up, end_dn, step_page;
    depth_t             depth_m1;
    logic               full;

    assign page_addr   = s_axis_tdata[ADDR_W-1:0];
    assign range_start = s_axis_tdata[2*ADDR_W-1:ADDR_W];
    assign range_end   = s_axis_tdata[3*ADDR_W-1:2*ADDR_W];

    always_comb begin
        start_sum = {1'b0, range_start} + {1'b0, PAGE_MASK};
        start_up  = start_sum[ADDR_W-1:0] & ~PAGE_MASK;
        end_dn    = range_end & ~PAGE_MASK;
        step_page = top_reg - addr_t'(PAGE_BYTES);
        depth_m1  = depth_reg - depth_t'(1);
        full      = depth_reg >= depth_t'(CAPACITY);
    end

    always_comb begin
        flags.action        = pfsa_action_t'(s_axis_tuser);
        flags.depth_zero    = depth_reg == '0;
        flags.enroll_empty  = start_sum[ADDR_W] || (end_dn <= start_up);
        flags.last_page     = step_page == base_reg;
        flags.step_overflow = (step_page != '0) && full;
        flags.out_free      = !m_valid_reg || m_axis_tready;
    end

    always_comb begin
        depth_next   = depth_reg;
        top_next     = top_reg;
        base_next    = base_reg;
        status_next  = status_reg;
        granted_next = granted_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = depth_reg[IDX_W-1:0];
        mem_raddr    = depth_m1[IDX_W-1:0];
        mem_wdata    = page_addr;

        if (cmd.capture) begin
            granted_next = '0;
            status_next  = ST_OK;
            case (flags.action)
                ACT_ALLOC: begin
                    if (flags.depth_zero) begin
                        status_next = ST_EMPTY;
                    end else begin
                        mem_re     = 1'b1;
                        depth_next = depth_m1;
                    end
                end
                ACT_FREE: begin
                    if (page_addr == '0) begin
                        status_next = ST_ZERO;
                    end else if (full) begin
                        status_next = ST_OVERFLOW;
                    end else begin
                        mem_we     = 1'b1;
                        depth_next = depth_reg + depth_t'(1);
                    end
                end
                ACT_ENROLL: begin
                    top_next  = end_dn;
                    base_next = start_up;
                end
                default: begin
                end
            endcase
        end

        if (cmd.enroll_step) begin
            top_next  = step_page;
            mem_wdata = step_page;
            if (step_page == '0) begin
                status_next = ST_ZERO;
            end else if (full) begin
                status_next = ST_OVERFLOW;
            end else begin
                mem_we     = 1'b1;
                depth_next = depth_reg + depth_t'(1);
            end
        end

        if (cmd.take_grant) begin
            granted_next = rd_data_reg;
        end
    end

    always_comb begin
        m_valid_next     = m_valid_reg;
        out_status_next  = out_status_reg;
        out_granted_next = out_granted_reg;
        out_pages_next   = out_pages_reg;
        if (cmd.emit) begin
            m_valid_next     = 1'b1;
            out_status_next  = status_reg;
            out_granted_next = granted_reg;
            out_pages_next   = FREE_W'(depth_reg);
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= stack_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            depth_reg   <= depth_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg         <= top_next;
        base_reg        <= base_next;
        status_reg      <= status_next;
        granted_reg     <= granted_next;
        out_status_reg  <= out_status_next;
        out_granted_reg <= out_granted_next;
        out_pages_reg   <= out_pages_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_pages_reg, out_granted_reg});

endmodule

// File: rtl/core/pfsa_ctrl.sv
// Controller: sequences accept, pop readback, enroll walk and result hand-off.
module pfsa_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  pfsa_pkg::pfsa_flags_t flags,
    output pfsa_pkg::pfsa_cmd_t   cmd
);
    import pfsa_pkg::*;

    pfsa_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        cmd           = '0;
        case (state_reg)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    cmd.capture = 1'b1;
                    case (flags.action)
                        ACT_ALLOC:  state_next = flags.depth_zero ? S_FINISH : S_GRANT;
                        ACT_ENROLL: state_next = flags.enroll_empty ? S_FINISH : S_ENROLL;
                        default:    state_next = S_FINISH;
                    endcase
                end
            end
            S_GRANT: begin
                cmd.take_grant = 1'b1;
                state_next     = S_FINISH;
            end
            S_ENROLL: begin
                cmd.enroll_step = 1'b1;
                if (flags.step_overflow || flags.last_page) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (flags.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/page_frame_stack_allocator_core.sv
// Top level of the page frame stack allocator.
//
// Keeps free physical page addresses on a LIFO stack of 4096 entries.
// Input channel (s_axis): tuser is the action (allocate, free, enroll range),
// tdata carries page_addr, range_start and range_end. Each input transfer
// yields exactly one result transfer on m_axis: tuser is the status, tdata
// carries granted_addr and the free page count after the action.
// Allocate pops the top entry through one registered read of the stack
// memory. Enroll walks the range page by page, one page pushed per cycle
// through the single memory write port; an overflow ends the walk early.
// One item is in work at a time; the next transfer is taken once the
// result sits in the output register. Reset empties the stack at once;
// no clearing pass is needed. While the receiver stalls, the result holds
// in the output register, one more item may be taken and worked, and its
// result waits until the register frees.
`include "page_frame_stack_allocator_core_macros.svh"

module page_frame_stack_allocator_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] page_addr, [63:32] range_start, [95:64] range_end
    input  logic [pfsa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [1:0] action
    input  logic [pfsa_pkg::ACT_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] granted_addr, [44:32] pages_free, [47:45] zero
    output logic [pfsa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // [1:0] status
    output logic [pfsa_pkg::STATUS_W-1:0]       m_axis_tuser
);
    import pfsa_pkg::*;

    pfsa_cmd_t   cmd;
    pfsa_flags_t flags;

    pfsa_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .flags         (flags),
        .cmd           (cmd)
    );

    pfsa_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd           (cmd),
        .flags         (flags),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    `PFSA_ASSERT_NEXT(a_one_item_in_work, aclk, aresetn, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while an item is in work")
    `PFSA_ASSERT_NOW(a_emit_needs_slot, aclk, aresetn, cmd.emit, flags.out_free, "result overwrote an untaken result")
    `PFSA_ASSERT_NOW(a_pages_bound, aclk, aresetn, m_axis_tvalid, m_axis_tdata[ADDR_W +: FREE_W] <= FREE_W'(CAPACITY), "free count above capacity")
    `PFSA_ASSERT_NOW(a_empty_no_grant, aclk, aresetn, m_axis_tvalid && (m_axis_tuser == ST_EMPTY), m_axis_tdata[ADDR_W-1:0] == '0, "address granted from empty stack")

endmodule
